FILE: hw/rtl/m4xf_pkg.sv
// ----------------------------------------------------------------------------
// m4xf_pkg: shared types and helpers for the 4x4 matrix transform unit
// Fixed-point widths, lane control, rounding and cofactor index tables.
// ----------------------------------------------------------------------------
package m4xf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int PROD_W    = 2 * W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int QW        = W + FRAC_BITS;
    localparam int CNT_W     = $clog2(QW + 1);
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 128;

    typedef logic signed [W-1:0]      word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_APPEND = 3'd1,
        OP_INVERT = 3'd2,
        OP_XFORM  = 3'd3,
        OP_IDENT  = 3'd4,
        OP_READ   = 3'd5,
        OP_NOP    = 3'd6
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SING = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam word_t ONE = word_t'(64'd1 << FRAC_BITS);
    localparam acc_t  HALF_ACC = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W:0] HALF_EXT = (ACC_W + 1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W:0] WMAX_EXT = (ACC_W + 1)'(64'h7FFF_FFFF);
    localparam logic signed [ACC_W:0] WMIN_EXT = -((ACC_W + 1)'(64'h8000_0000));
    localparam logic [QW-1:0]         DIV_LIM  = QW'(1) << (W - 1);

    typedef struct packed {
        logic mul;
        logic useq;
        logic ldq;
        logic acc;
        logic clr;
        logic neg;
    } lane_ctl_t;

    typedef struct packed {
        word_t val;
        logic  sat;
    } rs_t;

    // round to nearest (ties up) to FRAC_BITS, then clamp to 32 bits
    function automatic rs_t rnd_sat(input acc_t v);
        logic signed [ACC_W:0] r;
        rs_t o;
        r = $signed({v[ACC_W-1], v}) + HALF_EXT;
        r = r >>> FRAC_BITS;
        o.sat = 1'b0;
        if (r > WMAX_EXT) begin
            o.val = word_t'(32'h7FFF_FFFF);
            o.sat = 1'b1;
        end else if (r < WMIN_EXT) begin
            o.val = word_t'(32'h8000_0000);
            o.sat = 1'b1;
        end else begin
            o.val = r[W-1:0];
        end
        return o;
    endfunction

    // n-th index of 0..3 with x left out
    function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] n);
        return (n < x) ? n : n + 2'd1;
    endfunction

    function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] pos);
        logic [5:0] t;
        case (p)
            3'd0: t = {2'd2, 2'd1, 2'd0};
            3'd1: t = {2'd1, 2'd2, 2'd0};
            3'd2: t = {2'd2, 2'd0, 2'd1};
            3'd3: t = {2'd0, 2'd2, 2'd1};
            3'd4: t = {2'd1, 2'd0, 2'd2};
            3'd5: t = {2'd0, 2'd1, 2'd2};
            default: t = {2'd2, 2'd1, 2'd0};
        endcase
        return t[{pos, 1'b0} +: 2];
    endfunction

    function automatic logic perm_neg(input logic [2:0] p);
        return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
    endfunction

endpackage

FILE: hw/rtl/m4xf_lane.sv
// ----------------------------------------------------------------------------
// m4xf_lane: one multiply-accumulate lane
// Registered 32x32 product, exact wide accumulator, rounded product hold.
// ----------------------------------------------------------------------------
module m4xf_lane
    import m4xf_pkg::*;
(
    input  logic      aclk,
    input  lane_ctl_t ctl,
    input  word_t     a,
    input  word_t     b,
    output prod_t     prod,
    output rs_t       prod_rs,
    output rs_t       acc_rs
);

    prod_t prod_reg, prod_next;
    word_t q_reg, q_next;
    acc_t  acc_reg, acc_next;
    word_t ma;
    acc_t  addend;

    always_comb begin
        ma        = ctl.useq ? q_reg : a;
        prod_next = ctl.mul ? prod_t'(ma * b) : prod_reg;
        q_next    = ctl.ldq ? prod_rs.val : q_reg;
        addend    = acc_t'(prod_reg);
        if (ctl.neg) begin
            addend = -addend;
        end
        acc_next = acc_reg;
        if (ctl.acc) begin
            acc_next = (ctl.clr ? acc_t'(0) : acc_reg) + addend;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        q_reg    <= q_next;
        acc_reg  <= acc_next;
    end

    assign prod    = prod_reg;
    assign prod_rs = rnd_sat(acc_t'(prod_reg));
    assign acc_rs  = rnd_sat(acc_reg);

endmodule

FILE: hw/rtl/m4xf_merge.sv
// ----------------------------------------------------------------------------
// m4xf_merge: lane merge stage
// Sums the four lane products and rounds once to give the determinant.
// ----------------------------------------------------------------------------
module m4xf_merge
    import m4xf_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  prod_t prod [4],
    output acc_t  det
);

    acc_t det_reg, det_next;
    acc_t sum;

    always_comb begin
        sum = acc_t'(prod[0]) + acc_t'(prod[1]) + acc_t'(prod[2]) + acc_t'(prod[3])
            + HALF_ACC;
        det_next = en ? (sum >>> FRAC_BITS) : det_reg;
    end

    always_ff @(posedge aclk) begin
        det_reg <= det_next;
    end

    assign det = det_reg;

endmodule

FILE: hw/rtl/m4xf_div.sv
// ----------------------------------------------------------------------------
// m4xf_div: bit-serial signed divider
// cof * 2^FRAC_BITS / det, rounded half away from zero, clamped to 32 bits.
// ----------------------------------------------------------------------------
module m4xf_div
    import m4xf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  word_t cof,
    input  acc_t  det,
    output logic  done,
    output word_t q,
    output logic  sat
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0] ud_reg, ud_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic             neg_reg, neg_next;
    word_t            q_reg, q_next;
    logic             sat_reg, sat_next;

    logic [ACC_W:0]   t;
    logic [ACC_W:0]   diff;
    logic [ACC_W-1:0] det_u, ud_s, un_s;
    logic [W-1:0]     cof_u, cof_m;
    logic [ACC_W:0]   dvd;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        ud_next   = ud_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;

        det_u = det;
        ud_s  = det[ACC_W-1] ? ~det_u + 1'b1 : det_u;
        cof_u = cof;
        cof_m = cof[W-1] ? ~cof_u + 1'b1 : cof_u;
        un_s  = ACC_W'(cof_m) << FRAC_BITS;
        dvd   = {1'b0, un_s} + {1'b0, ud_s >> 1};

        t    = {rem_reg, quo_reg[QW-1]};
        diff = t - {1'b0, ud_reg};

        if (start) begin
            busy_next = 1'b1;
            ud_next   = ud_s;
            rem_next  = ACC_W'(dvd >> QW);
            quo_next  = dvd[QW-1:0];
            cnt_next  = CNT_W'(QW);
            neg_next  = cof[W-1] ^ det[ACC_W-1];
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                if (t >= {1'b0, ud_reg}) begin
                    rem_next = diff[ACC_W-1:0];
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end else begin
                    rem_next = t[ACC_W-1:0];
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
                sat_next  = 1'b0;
                if (neg_reg) begin
                    if (quo_reg > DIV_LIM) begin
                        q_next   = word_t'(32'h8000_0000);
                        sat_next = 1'b1;
                    end else begin
                        q_next = -$signed(quo_reg[W-1:0]);
                    end
                end else begin
                    if (quo_reg > DIV_LIM - 1'b1) begin
                        q_next   = word_t'(32'h7FFF_FFFF);
                        sat_next = 1'b1;
                    end else begin
                        q_next = $signed(quo_reg[W-1:0]);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        ud_reg  <= ud_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign sat  = sat_reg;

endmodule

FILE: hw/rtl/matrix4x4_transform_unit.sv
// ----------------------------------------------------------------------------
// matrix4x4_transform_unit: 4x4 Q16.16 affine matrix unit
// Load, read, identity, append (M = M * B), invert and point transform.
// Load, identity, read, nop and append rows 0..2 go from idle straight to the result stage.
// Transform: four MAC lanes over the four matrix rows.
// Append row 3: one MAC pass per result row.
// Invert: cofactors, determinant, then the bit-serial divider (48 steps per entry).
// Reset loads the identity matrix and clears the output valid flag.
// ----------------------------------------------------------------------------
module matrix4x4_transform_unit
    import m4xf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // row[1:0], elem0..elem3, zero pad
    input  logic [2:0]           s_tuser,  // operation
    input  logic                 s_tlast,  // batch_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // out0, out1, out2, out3
    output logic [1:0]           m_tuser,  // status
    output logic                 m_tlast   // batch_end_out
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAC  = 6'b000010,
        S_COF  = 6'b000100,
        S_DET  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    op_t        op_reg, op_next;
    word_t      elem_reg [4];
    word_t      elem_next [4];
    logic       last_reg, last_next;
    logic [1:0] i_reg, i_next;
    logic [2:0] s_reg, s_next;
    logic [2:0] p_reg, p_next;
    logic [1:0] ph_reg, ph_next;
    logic [3:0] e_reg, e_next;
    logic       sat_reg, sat_next;
    logic [1:0] res_status_reg, res_status_next;
    word_t      res_out_reg [4];
    word_t      res_out_next [4];
    word_t      mat_reg [4][4];
    word_t      mat_next [4][4];
    word_t      opr_reg [3][4];
    word_t      opr_next [3][4];
    word_t      cof_reg [4][4];
    word_t      cof_next [4][4];
    logic       m_valid_reg, m_valid_next;
    word_t      m_out_reg [4];
    word_t      m_out_next [4];
    logic [1:0] m_status_reg, m_status_next;
    logic       m_last_reg, m_last_next;

    lane_ctl_t  ctl [4];
    word_t      la [4];
    word_t      lb [4];
    prod_t      prod [4];
    rs_t        prod_rs [4];
    rs_t        acc_rs [4];
    acc_t       det;
    logic       merge_en;
    logic       div_start;
    logic       div_done;
    word_t      div_q;
    logic       div_sat;
    word_t      in_elem [4];
    logic [1:0] in_row;
    op_t        in_op;

    assign in_row = s_tdata[1:0];
    assign in_op  = op_t'(s_tuser);

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            assign in_elem[g] = s_tdata[2 + W * g +: W];
            m4xf_lane u_lane (
                .aclk    (aclk),
                .ctl     (ctl[g]),
                .a       (la[g]),
                .b       (lb[g]),
                .prod    (prod[g]),
                .prod_rs (prod_rs[g]),
                .acc_rs  (acc_rs[g])
            );
        end
    endgenerate

    m4xf_merge u_merge (
        .aclk (aclk),
        .en   (merge_en),
        .prod (prod),
        .det  (det)
    );

    m4xf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .cof     (cof_reg[e_reg[3:2]][e_reg[1:0]]),
        .det     (det),
        .done    (div_done),
        .q       (div_q),
        .sat     (div_sat)
    );

    always_comb begin
        logic [1:0] k;
        logic [1:0] r0, r1, r2;
        logic [1:0] pc0, pc1, pc2;
        logic       any_sat;

        state_next      = state_reg;
        op_next         = op_reg;
        elem_next       = elem_reg;
        last_next       = last_reg;
        i_next          = i_reg;
        s_next          = s_reg;
        p_next          = p_reg;
        ph_next         = ph_reg;
        e_next          = e_reg;
        sat_next        = sat_reg;
        res_status_next = res_status_reg;
        res_out_next    = res_out_reg;
        mat_next        = mat_reg;
        opr_next        = opr_reg;
        cof_next        = cof_reg;
        m_valid_next    = m_valid_reg & ~m_tready;
        m_out_next      = m_out_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;
        merge_en        = 1'b0;
        div_start       = 1'b0;
        any_sat         = 1'b0;

        k   = s_reg[1:0];
        r0  = skip_idx(i_reg, 2'd0);
        r1  = skip_idx(i_reg, 2'd1);
        r2  = skip_idx(i_reg, 2'd2);
        pc0 = perm_col(p_reg, 2'd0);
        pc1 = perm_col(p_reg, 2'd1);
        pc2 = perm_col(p_reg, 2'd2);

        for (int c = 0; c < 4; c++) begin
            ctl[c] = '0;
            la[c]  = '0;
            lb[c]  = '0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = in_op;
                    elem_next       = in_elem;
                    last_next       = s_tlast;
                    sat_next        = 1'b0;
                    i_next          = '0;
                    s_next          = '0;
                    p_next          = '0;
                    ph_next         = '0;
                    e_next          = '0;
                    res_status_next = ST_OK;
                    for (int c = 0; c < 4; c++) begin
                        res_out_next[c] = '0;
                    end
                    state_next = S_DONE;
                    case (in_op)
                        OP_LOAD: begin
                            for (int c = 0; c < 4; c++) begin
                                mat_next[in_row][c] = in_elem[c];
                            end
                        end
                        OP_APPEND: begin
                            if (in_row == 2'd3) begin
                                state_next = S_MAC;
                            end else begin
                                for (int c = 0; c < 4; c++) begin
                                    opr_next[in_row][c] = in_elem[c];
                                end
                            end
                        end
                        OP_INVERT: begin
                            state_next = S_COF;
                        end
                        OP_XFORM: begin
                            state_next = S_MAC;
                        end
                        OP_IDENT: begin
                            for (int r = 0; r < 4; r++) begin
                                for (int c = 0; c < 4; c++) begin
                                    mat_next[r][c] = (r == c) ? ONE : word_t'(0);
                                end
                            end
                        end
                        OP_READ: begin
                            for (int c = 0; c < 4; c++) begin
                                res_out_next[c] = mat_reg[in_row][c];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_MAC: begin
                for (int c = 0; c < 4; c++) begin
                    if (op_reg == OP_XFORM) begin
                        la[c] = (k == 2'd3) ? ONE : elem_reg[k];
                        lb[c] = mat_reg[k][c];
                    end else begin
                        la[c] = mat_reg[i_reg][k];
                        lb[c] = (k == 2'd3) ? elem_reg[c] : opr_reg[k][c];
                    end
                    ctl[c].mul = (s_reg < 3'd4);
                    ctl[c].acc = (s_reg != 3'd0) && (s_reg <= 3'd4);
                    ctl[c].clr = (s_reg == 3'd1);
                end
                s_next = s_reg + 3'd1;
                if (s_reg == 3'd5) begin
                    s_next = '0;
                    if (op_reg == OP_XFORM) begin
                        for (int c = 0; c < 3; c++) begin
                            res_out_next[c] = acc_rs[c].val;
                            any_sat         = any_sat | acc_rs[c].sat;
                        end
                        res_status_next = any_sat ? ST_SAT : ST_OK;
                        state_next      = S_DONE;
                    end else begin
                        any_sat = sat_reg;
                        for (int c = 0; c < 4; c++) begin
                            mat_next[i_reg][c] = acc_rs[c].val;
                            any_sat            = any_sat | acc_rs[c].sat;
                        end
                        sat_next = any_sat;
                        i_next   = i_reg + 2'd1;
                        if (i_reg == 2'd3) begin
                            res_status_next = any_sat ? ST_SAT : ST_OK;
                            state_next      = S_DONE;
                        end
                    end
                end
            end

            S_COF: begin
                if (p_reg == 3'd6) begin
                    any_sat = sat_reg;
                    for (int j = 0; j < 4; j++) begin
                        cof_next[i_reg][j] = acc_rs[j].val;
                        any_sat            = any_sat | acc_rs[j].sat;
                    end
                    sat_next = any_sat;
                    p_next   = '0;
                    ph_next  = '0;
                    i_next   = i_reg + 2'd1;
                    if (i_reg == 2'd3) begin
                        s_next     = '0;
                        state_next = S_DET;
                    end
                end else begin
                    any_sat = sat_reg;
                    for (int j = 0; j < 4; j++) begin
                        case (ph_reg)
                            2'd0: begin
                                la[j]      = mat_reg[r0][skip_idx(2'(j), pc0)];
                                lb[j]      = mat_reg[r1][skip_idx(2'(j), pc1)];
                                ctl[j].mul = 1'b1;
                            end
                            2'd1: begin
                                ctl[j].ldq = 1'b1;
                                any_sat    = any_sat | prod_rs[j].sat;
                            end
                            2'd2: begin
                                ctl[j].useq = 1'b1;
                                lb[j]       = mat_reg[r2][skip_idx(2'(j), pc2)];
                                ctl[j].mul  = 1'b1;
                            end
                            default: begin
                                ctl[j].acc = 1'b1;
                                ctl[j].clr = (p_reg == 3'd0);
                                ctl[j].neg = perm_neg(p_reg) ^ i_reg[0] ^ (j % 2 == 1);
                            end
                        endcase
                    end
                    sat_next = any_sat;
                    ph_next  = ph_reg + 2'd1;
                    if (ph_reg == 2'd3) begin
                        p_next = p_reg + 3'd1;
                    end
                end
            end

            S_DET: begin
                for (int c = 0; c < 4; c++) begin
                    la[c]      = mat_reg[0][c];
                    lb[c]      = cof_reg[0][c];
                    ctl[c].mul = (s_reg == 3'd0);
                end
                merge_en = (s_reg == 3'd1);
                s_next   = s_reg + 3'd1;
                if (s_reg == 3'd2) begin
                    s_next = '0;
                    e_next = '0;
                    if (det == '0) begin
                        res_status_next = ST_SING;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV: begin
                if (s_reg == 3'd0) begin
                    div_start = 1'b1;
                    s_next    = 3'd1;
                end else if (div_done) begin
                    mat_next[e_reg[1:0]][e_reg[3:2]] = div_q;
                    any_sat  = sat_reg | div_sat;
                    sat_next = any_sat;
                    s_next   = '0;
                    e_next   = e_reg + 4'd1;
                    if (e_reg == 4'd15) begin
                        res_status_next = any_sat ? ST_SAT : ST_OK;
                        state_next      = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_out_next    = res_out_reg;
                    m_status_next = res_status_reg;
                    m_last_next   = last_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            i_reg       <= '0;
            s_reg       <= '0;
            p_reg       <= '0;
            ph_reg      <= '0;
            e_reg       <= '0;
            sat_reg     <= 1'b0;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    mat_reg[r][c] <= (r == c) ? ONE : word_t'(0);
                end
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            i_reg       <= i_next;
            s_reg       <= s_next;
            p_reg       <= p_next;
            ph_reg      <= ph_next;
            e_reg       <= e_next;
            sat_reg     <= sat_next;
            mat_reg     <= mat_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        elem_reg       <= elem_next;
        last_reg       <= last_next;
        res_status_reg <= res_status_next;
        res_out_reg    <= res_out_next;
        opr_reg        <= opr_next;
        cof_reg        <= cof_next;
        m_out_reg      <= m_out_next;
        m_status_reg   <= m_status_next;
        m_last_reg     <= m_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_out_reg[3], m_out_reg[2], m_out_reg[1], m_out_reg[0]};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule
